[rtl/delimited_frame_receive_queue_assert.svh]
// Assertion shorthands shared by the frame queue modules.
// Each one expects signals named clk and rst in the module that uses it.
`ifndef DELIMITED_FRAME_RECEIVE_QUEUE_ASSERT_SVH
`define DELIMITED_FRAME_RECEIVE_QUEUE_ASSERT_SVH

// A condition that holds at every edge outside reset.
`define DFRQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its cause.
`define DFRQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A consequence that holds in the cycle after its cause.
`define DFRQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/dfrq_pkg.sv]
package dfrq_pkg;

  localparam int FRAME_MAX = 32;
  localparam int SLOTS     = 8;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 6;
  localparam int MIN_W  = 5;
  localparam int CNT_W  = $clog2(FRAME_MAX + 1);
  localparam int IDX_W  = $clog2(FRAME_MAX);
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int FW_W   = $clog2(SLOTS + 1);
  localparam int CMP_W  = (CNT_W > MIN_W) ? CNT_W : MIN_W;

  localparam int OUT_TDATA_W = ((BYTE_W + LEN_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - BYTE_W - LEN_W;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [BYTE_W-1:0] START_BYTE = 8'hF1;
  localparam logic [BYTE_W-1:0] END_BYTE   = 8'hF2;
  localparam logic [MIN_W-1:0]  MIN_RESET  = 5'd4;

  localparam logic CMD_RX   = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_START,
    KIND_END,
    KIND_READ
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
  } item_t;

endpackage

[rtl/dfrq_front.sv]
module dfrq_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [dfrq_pkg::BYTE_W-1:0] s_axis_tdata,  // rx_byte
  input  logic                        s_axis_tuser,  // command
  output logic                        q_valid,
  input  logic                        q_ready,
  output dfrq_pkg::item_t             q_item
);
  import dfrq_pkg::*;

  `include "delimited_frame_receive_queue_assert.svh"

  item_t             fifo [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  item_t             item_in;
  logic              push;
  logic              pop;

  // Decode the byte once here so the back end only looks at the kind.
  always_comb begin
    item_in.data = s_axis_tdata;
    if (s_axis_tuser == CMD_READ) begin
      item_in.kind = KIND_READ;
    end else if (s_axis_tdata == START_BYTE) begin
      item_in.kind = KIND_START;
    end else if (s_axis_tdata == END_BYTE) begin
      item_in.kind = KIND_END;
    end else begin
      item_in.kind = KIND_DATA;
    end
  end

  assign s_axis_tready = (count != QCNT_W'(QDEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (count != '0);
  assign pop           = q_valid && q_ready;
  assign q_item        = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  `DFRQ_ASSERT_ALWAYS(a_q_count_range, count <= QCNT_W'(QDEPTH), "queue count past its depth")
  `DFRQ_ASSERT_NEXT(a_q_pop_drains, pop && !push, count == $past(count) - QCNT_W'(1), "pop without push did not drain the queue")

endmodule

[rtl/dfrq_back.sv]
module dfrq_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wen,
  input  logic [dfrq_pkg::MIN_W-1:0]  cfg_wdata,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  dfrq_pkg::item_t             q_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dfrq_pkg::BYTE_W-1:0] out_byte,
  output logic [dfrq_pkg::LEN_W-1:0]  out_length,
  output logic                        out_last,
  output logic                        out_empty
);
  import dfrq_pkg::*;

  `include "delimited_frame_receive_queue_assert.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_READ
  } state_t;

  state_t            state;
  logic [MIN_W-1:0]  min_len;

  // Frame being assembled.
  logic [BYTE_W-1:0] asm_mem [FRAME_MAX];
  logic [BYTE_W-1:0] asm_q;
  logic [CNT_W-1:0]  asm_count;
  logic              in_frame;

  // Ring of stored frames.
  logic [BYTE_W-1:0] slot_mem [SLOTS][FRAME_MAX];
  logic [CNT_W-1:0]  slot_len [SLOTS];
  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] read_slot;
  logic [FW_W-1:0]   frames_waiting;

  // Copy from the assembly buffer into a slot.
  logic [SLOT_W-1:0] cp_slot;
  logic [CNT_W-1:0]  cp_len;
  logic [CNT_W-1:0]  cp_idx;
  logic              cp_wr_valid;
  logic [IDX_W-1:0]  cp_wr_idx;

  // Readout of one slot.
  logic [SLOT_W-1:0] rd_slot;
  logic [CNT_W-1:0]  rd_len;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_last;

  // Memory read stage, then the output register.
  logic [BYTE_W-1:0] mem_q;
  logic              s1_valid;
  logic [LEN_W-1:0]  s1_len;
  logic              s1_last;
  logic              s1_empty;
  logic              s1_load;
  logic              advance;

  logic              pop;
  logic              store_ok;
  logic              store_frame;
  logic              asm_we;
  logic [IDX_W-1:0]  asm_waddr;
  logic [CNT_W-1:0]  count_inc;
  logic [SLOT_W-1:0] write_slot_inc;
  logic [SLOT_W-1:0] read_slot_inc;

  assign advance = !out_valid || out_ready;

  // A read command is only taken when the output pipe can move, so the
  // empty result always has a place to go.
  assign pop = q_valid && (state == ST_IDLE) && ((q_item.kind != KIND_READ) || advance);
  assign q_ready = (state == ST_IDLE) && ((q_item.kind != KIND_READ) || advance);

  // The read stage takes a new item on a frame byte or on an empty read.
  assign s1_load = advance && ((state == ST_READ) ||
                               (pop && (q_item.kind == KIND_READ) && (frames_waiting == '0)));

  assign count_inc = asm_count + CNT_W'(1);
  assign store_ok  = in_frame && (CMP_W'(asm_count) >= CMP_W'(min_len))
                     && (asm_count < CNT_W'(FRAME_MAX));
  assign store_frame = pop && (q_item.kind == KIND_END) && store_ok;

  assign asm_we = pop && (((q_item.kind == KIND_START) && !in_frame) ||
                          store_frame ||
                          ((q_item.kind == KIND_DATA) && in_frame));
  assign asm_waddr = (q_item.kind == KIND_START) ? '0 : asm_count[IDX_W-1:0];

  assign write_slot_inc = (write_slot == SLOT_W'(SLOTS - 1)) ? '0 : write_slot + SLOT_W'(1);
  assign read_slot_inc  = (read_slot == SLOT_W'(SLOTS - 1)) ? '0 : read_slot + SLOT_W'(1);
  assign rd_last = ((CNT_W'(rd_idx) + CNT_W'(1)) == rd_len);

  always_ff @(posedge clk) begin
    if (asm_we) begin
      asm_mem[asm_waddr] <= q_item.data;
    end
    asm_q <= asm_mem[cp_idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cp_wr_valid) begin
      slot_mem[cp_slot][cp_wr_idx] <= asm_q;
    end
    if (advance) begin
      mem_q <= slot_mem[rd_slot][rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (store_frame) begin
      slot_len[write_slot] <= count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      min_len        <= MIN_RESET;
      asm_count      <= '0;
      in_frame       <= 1'b0;
      write_slot     <= '0;
      read_slot      <= '0;
      frames_waiting <= '0;
      cp_wr_valid    <= 1'b0;
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wen) begin
        min_len <= cfg_wdata;
      end
      cp_wr_valid <= (state == ST_COPY) && (cp_idx != cp_len);

      if (advance) begin
        out_valid  <= s1_valid;
        out_byte   <= s1_empty ? '0 : mem_q;
        out_length <= s1_len;
        out_last   <= s1_last;
        out_empty  <= s1_empty;
        s1_valid   <= s1_load;
      end

      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            case (q_item.kind)
              KIND_START: begin
                if (!in_frame) begin
                  asm_count <= CNT_W'(1);
                  in_frame  <= 1'b1;
                end
              end
              KIND_END: begin
                if (store_ok) begin
                  cp_slot    <= write_slot;
                  cp_len     <= count_inc;
                  cp_idx     <= '0;
                  write_slot <= write_slot_inc;
                  if (frames_waiting != FW_W'(SLOTS)) begin
                    frames_waiting <= frames_waiting + FW_W'(1);
                  end
                  state <= ST_COPY;
                end
                asm_count <= '0;
                in_frame  <= 1'b0;
              end
              KIND_DATA: begin
                if (in_frame) begin
                  // Reaching the size limit without an end byte drops the frame.
                  if (count_inc >= CNT_W'(FRAME_MAX)) begin
                    asm_count <= '0;
                    in_frame  <= 1'b0;
                  end else begin
                    asm_count <= count_inc;
                  end
                end
              end
              default: begin
                if (frames_waiting == '0) begin
                  s1_len   <= '0;
                  s1_last  <= 1'b1;
                  s1_empty <= 1'b1;
                end else begin
                  rd_slot        <= read_slot;
                  rd_len         <= slot_len[read_slot];
                  rd_idx         <= '0;
                  read_slot      <= read_slot_inc;
                  frames_waiting <= frames_waiting - FW_W'(1);
                  state          <= ST_READ;
                end
              end
            endcase
          end
        end
        ST_COPY: begin
          // The final write lands in the cycle that returns to idle.
          if (cp_idx != cp_len) begin
            cp_wr_idx   <= cp_idx[IDX_W-1:0];
            cp_idx      <= cp_idx + CNT_W'(1);
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_READ: begin
          if (advance) begin
            s1_len   <= LEN_W'(rd_len);
            s1_last  <= rd_last;
            s1_empty <= 1'b0;
            rd_idx   <= rd_idx + IDX_W'(1);
            if (rd_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `DFRQ_ASSERT_ALWAYS(a_fw_range, frames_waiting <= FW_W'(SLOTS), "frames waiting past slot count")
  `DFRQ_ASSERT_IMPL(a_open_count, in_frame, (asm_count != '0) && (asm_count < CNT_W'(FRAME_MAX)), "open frame count out of range")
  `DFRQ_ASSERT_IMPL(a_closed_count, !in_frame, asm_count == '0, "closed frame holds bytes")
  `DFRQ_ASSERT_IMPL(a_read_len, state == ST_READ, (rd_len >= CNT_W'(2)) && (rd_len <= CNT_W'(FRAME_MAX)), "stored frame length out of range")
  `DFRQ_ASSERT_NEXT(a_empty_read, pop && (q_item.kind == KIND_READ) && (frames_waiting == '0), s1_valid && s1_empty && s1_last, "empty read gave no empty result")

endmodule

[rtl/delimited_frame_receive_queue.sv]
// Receive-side frame queue.
// The input stream carries one item per byte received on the serial line
// (tuser low, tdata the byte) or a read command (tuser high). Bytes between a
// start byte 0xF1 and an end byte 0xF2 are assembled into a frame; frames
// that are too short at the end byte or reach 32 bytes without one are
// dropped. Complete frames, delimiters included, go into a ring of 8 slots;
// when the ring is full the newest frame overwrites the slot at the write
// pointer. A read command returns the oldest frame one byte per item with
// its length, tlast on the final byte, or a single item flagged empty.
// Received bytes are taken at one per cycle through a 4-entry queue. A
// completed frame then occupies the storage engine while it is copied into
// its slot, so a byte stream that follows closely backs up into the queue
// and tready drops for that time. A read command passes through the queue to
// the engine, its result through the read stage and the output register; a
// stored frame then follows at one item per cycle. The output register
// stalls the engine while tready is low; nothing is lost. Reset clears the
// pointers, counters and the open frame at once; slot contents are not cleared.
// min_frame_length is written through cfg_wen/cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce.
module delimited_frame_receive_queue (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [dfrq_pkg::MIN_W-1:0]       cfg_wdata,      // min_frame_length
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [dfrq_pkg::BYTE_W-1:0]      s_axis_tdata,   // rx_byte
  input  logic                             s_axis_tuser,   // command
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [dfrq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // frame_byte, frame_length, zeros
  output logic                             m_axis_tlast,   // last
  output logic                             m_axis_tuser    // empty_res
);
  import dfrq_pkg::*;

  logic              q_valid;
  logic              q_ready;
  item_t             q_item;
  logic [BYTE_W-1:0] frame_byte;
  logic [LEN_W-1:0]  frame_length;

  dfrq_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item)
  );

  dfrq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_byte   (frame_byte),
    .out_length (frame_length),
    .out_last   (m_axis_tlast),
    .out_empty  (m_axis_tuser)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, frame_length, frame_byte};

endmodule
